// File: hdl/hqt_pkg.sv
// ----------------------------------------------------------------------------
// hqt_pkg
// Shared types and constants for the hierarchical quota table.
// ----------------------------------------------------------------------------
package hqt_pkg;

	localparam int PARENT_W = 8;
	localparam int WEIGHT_W = 14;

	localparam logic [2:0] OP_CREATE     = 3'd0;
	localparam logic [2:0] OP_CHARGE     = 3'd1;
	localparam logic [2:0] OP_SET_LIMIT  = 3'd2;
	localparam logic [2:0] OP_SET_WEIGHT = 3'd3;
	localparam logic [2:0] OP_CREATE_POD = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_LIMIT    = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_INACTIVE = 2'd3;

	localparam logic [63:0]         ALL_ONES       = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0]         POD_MB_MAX     = 64'h0000_0FFF_FFFF_FFFF;
	localparam logic [WEIGHT_W-1:0] DEFAULT_WEIGHT = 14'd100;
	localparam logic [WEIGHT_W-1:0] MAX_WEIGHT     = 14'd10000;
	localparam logic [WEIGHT_W-1:0] POD_WEIGHT_CAP = 14'd1000;

	typedef struct packed {
		logic [PARENT_W-1:0] parent;
		logic [63:0]         limit;
		logic [63:0]         usage;
		logic [WEIGHT_W-1:0] weight;
	} entry_t;

endpackage

// File: hdl/hqt_mem.sv
// ----------------------------------------------------------------------------
// hqt_mem
// Group table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hqt_mem
	import hqt_pkg::*;
#(
	parameter int GROUP_COUNT = 32,
	localparam int IW = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [IW-1:0] waddr,
	input  entry_t        wdata,
	input  logic          re,
	input  logic [IW-1:0] raddr,
	output entry_t        rdata
);

	entry_t mem [GROUP_COUNT];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/hqt_ctrl.sv
// ----------------------------------------------------------------------------
// hqt_ctrl
// Command sequencer: allocation counter, ancestor walks and read-modify-write
// of the group table.
// ----------------------------------------------------------------------------
module hqt_ctrl
	import hqt_pkg::*;
#(
	parameter int GROUP_COUNT = 32,
	localparam int IW = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [2:0]    opcode,
	input  logic [4:0]    group_index,
	input  logic [4:0]    parent_index,
	input  logic [63:0]   amount,
	input  logic [31:0]   cpu_value,
	output logic          busy,
	output logic          done,
	output logic [1:0]    status,
	output logic [4:0]    new_index,
	output logic          mem_we,
	output logic [IW-1:0] mem_waddr,
	output entry_t        mem_wdata,
	output logic          mem_re,
	output logic [IW-1:0] mem_raddr,
	input  entry_t        mem_rdata
);

	localparam logic [2:0] S_INIT   = 3'd0;
	localparam logic [2:0] S_IDLE   = 3'd1;
	localparam logic [2:0] S_CREATE = 3'd2;
	localparam logic [2:0] S_SET    = 3'd3;
	localparam logic [2:0] S_CHK    = 3'd4;
	localparam logic [2:0] S_ADD    = 3'd5;

	logic [2:0]    state_q, state_d;
	logic [IW-1:0] count_q, count_d;
	logic [IW-1:0] cur_q, cur_d;
	logic [IW-1:0] gi_q;
	logic [2:0]    op_q;
	logic [63:0]   amt_q;
	logic [31:0]   cpu_q;
	logic          done_q, done_d;
	logic [1:0]    status_q, status_d;
	logic [4:0]    new_index_q, new_index_d;

	logic          accept;
	logic          gi_live, pi_live, full;
	logic [IW-1:0] next_idx;
	logic [IW-1:0] rd_parent;
	logic [64:0]   sum;
	logic          over;
	logic [63:0]   pod_limit;
	logic [WEIGHT_W-1:0] pod_weight, set_weight;

	// Groups are never freed and are taken in order, so the active entries are
	// exactly 0 up to the allocation count.
	assign gi_live   = (9'(group_index) <= 9'(count_q));
	assign pi_live   = (9'(parent_index) <= 9'(count_q));
	assign full      = (count_q == IW'(GROUP_COUNT - 1));
	assign next_idx  = count_q + IW'(1);
	assign accept    = start && (state_q == S_IDLE);
	assign rd_parent = mem_rdata.parent[IW-1:0];

	assign sum  = {1'b0, mem_rdata.usage} + {1'b0, amt_q};
	assign over = (sum > {1'b0, mem_rdata.limit});

	assign pod_limit  = (amt_q > POD_MB_MAX) ? ALL_ONES : {amt_q[43:0], 20'd0};
	assign pod_weight = (cpu_q > 32'(POD_WEIGHT_CAP)) ? POD_WEIGHT_CAP : cpu_q[WEIGHT_W-1:0];
	assign set_weight = (amt_q == 64'd0) ? WEIGHT_W'(1) :
		(amt_q > 64'(MAX_WEIGHT)) ? MAX_WEIGHT : amt_q[WEIGHT_W-1:0];

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		cur_d       = cur_q;
		done_d      = 1'b0;
		status_d    = status_q;
		new_index_d = new_index_q;
		mem_we      = 1'b0;
		mem_waddr   = cur_q;
		mem_wdata   = mem_rdata;
		mem_re      = 1'b0;
		mem_raddr   = cur_q;

		unique case (state_q)
			S_INIT: begin
				mem_we           = 1'b1;
				mem_waddr        = '0;
				mem_wdata.parent = '0;
				mem_wdata.limit  = ALL_ONES;
				mem_wdata.usage  = 64'd0;
				mem_wdata.weight = DEFAULT_WEIGHT;
				state_d          = S_IDLE;
			end
			S_IDLE: begin
				if (accept) begin
					new_index_d = 5'd0;
					priority if (opcode == OP_CREATE || opcode == OP_CREATE_POD) begin
						if (full) begin
							done_d   = 1'b1;
							status_d = ST_FULL;
						end else begin
							cur_d     = (opcode == OP_CREATE && pi_live) ?
								IW'(parent_index) : '0;
							mem_re    = 1'b1;
							mem_raddr = cur_d;
							state_d   = S_CREATE;
						end
					end else if (opcode == OP_CHARGE || opcode == OP_SET_LIMIT ||
						opcode == OP_SET_WEIGHT) begin
						if (!gi_live) begin
							done_d   = 1'b1;
							status_d = ST_INACTIVE;
						end else begin
							cur_d     = IW'(group_index);
							mem_re    = 1'b1;
							mem_raddr = IW'(group_index);
							state_d   = (opcode == OP_CHARGE) ? S_CHK : S_SET;
						end
					end else begin
						done_d   = 1'b1;
						status_d = ST_OK;
					end
				end
			end
			S_CREATE: begin
				mem_we           = 1'b1;
				mem_waddr        = next_idx;
				mem_wdata.parent = PARENT_W'(cur_q);
				mem_wdata.limit  = (op_q == OP_CREATE_POD && amt_q != 64'd0) ?
					pod_limit : mem_rdata.limit;
				mem_wdata.usage  = 64'd0;
				mem_wdata.weight = (op_q == OP_CREATE_POD && cpu_q != 32'd0) ?
					pod_weight : DEFAULT_WEIGHT;
				count_d          = next_idx;
				done_d           = 1'b1;
				status_d         = ST_OK;
				new_index_d      = 5'(next_idx);
				state_d          = S_IDLE;
			end
			S_SET: begin
				mem_we = 1'b1;
				if (op_q == OP_SET_LIMIT) begin
					mem_wdata.limit = amt_q;
				end else begin
					mem_wdata.weight = set_weight;
				end
				done_d   = 1'b1;
				status_d = ST_OK;
				state_d  = S_IDLE;
			end
			S_CHK: begin
				// First walk: test every level before anything is written.
				priority if (over) begin
					done_d   = 1'b1;
					status_d = ST_LIMIT;
					state_d  = S_IDLE;
				end else if (cur_q == '0) begin
					cur_d     = gi_q;
					mem_re    = 1'b1;
					mem_raddr = gi_q;
					state_d   = S_ADD;
				end else begin
					cur_d     = rd_parent;
					mem_re    = 1'b1;
					mem_raddr = rd_parent;
				end
			end
			S_ADD: begin
				// Second walk: write back this level and read the next one up.
				mem_we          = 1'b1;
				mem_wdata.usage = sum[63:0];
				if (cur_q == '0) begin
					done_d   = 1'b1;
					status_d = ST_OK;
					state_d  = S_IDLE;
				end else begin
					cur_d     = rd_parent;
					mem_re    = 1'b1;
					mem_raddr = rd_parent;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			count_q     <= '0;
			done_q      <= 1'b0;
			status_q    <= ST_OK;
			new_index_q <= 5'd0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			done_q      <= done_d;
			status_q    <= status_d;
			new_index_q <= new_index_d;
		end
	end

	always_ff @(posedge clk) begin
		cur_q <= cur_d;
		if (accept) begin
			op_q  <= opcode;
			gi_q  <= IW'(group_index);
			amt_q <= amount;
			cpu_q <= cpu_value;
		end
	end

	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign status    = status_q;
	assign new_index = new_index_q;

endmodule

// File: hdl/hierarchical_quota_table.sv
// ----------------------------------------------------------------------------
// hierarchical_quota_table
// Table of resource groups with limits, usage and weights kept in one memory.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low; its result shows
// on status and new_index for exactly one cycle with done high, and must be
// captured then, since the block cannot be held off. Words that are rejected
// at once (table full, inactive group, unused opcode) answer on the next cycle
// with busy staying low. Create, create pod, set limit and set weight keep busy
// high while they do one table read, then one write. A charge reads one table
// entry per cycle up the ancestor chain to test every level, then walks the
// chain again writing each level back, keeping busy high throughout; a level
// that rejects ends the charge during the first walk, with nothing written.
// After reset the root entry is written before the first word is taken.
module hierarchical_quota_table
	import hqt_pkg::*;
#(
	parameter int GROUP_COUNT = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [2:0]  opcode,
	input  logic [4:0]  group_index,
	input  logic [4:0]  parent_index,
	input  logic [63:0] amount,
	input  logic [31:0] cpu_value,
	output logic        busy,
	output logic        done,
	output logic [1:0]  status,
	output logic [4:0]  new_index
);

	localparam int IW = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;

	logic          mem_we;
	logic [IW-1:0] mem_waddr;
	entry_t        mem_wdata;
	logic          mem_re;
	logic [IW-1:0] mem_raddr;
	entry_t        mem_rdata;

	hqt_ctrl #(
		.GROUP_COUNT(GROUP_COUNT)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.opcode       (opcode),
		.group_index  (group_index),
		.parent_index (parent_index),
		.amount       (amount),
		.cpu_value    (cpu_value),
		.busy         (busy),
		.done         (done),
		.status       (status),
		.new_index    (new_index),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.mem_re       (mem_re),
		.mem_raddr    (mem_raddr),
		.mem_rdata    (mem_rdata)
	);

	hqt_mem #(
		.GROUP_COUNT(GROUP_COUNT)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

// File: hdl/hqt_chk.sv
// ----------------------------------------------------------------------------
// hqt_chk
// Port-level checks of the quota table's command and result behavior.
// ----------------------------------------------------------------------------
module hqt_chk
	import hqt_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [1:0] status,
	input logic [4:0] new_index
);

	// An accepted word either answers on the next cycle or keeps the block busy.
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> done || busy)
		else $error("accepted word neither answered nor held busy");

	// A result is only given once the block is free again.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	// Only a successful create may report an allocated index.
	a_index_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && new_index != 5'd0 |-> status == ST_OK)
		else $error("new index reported with failure status");

	// A result follows either an acceptance or the end of a busy stretch.
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy) || $past(busy))
		else $error("result without a command");

endmodule

bind hierarchical_quota_table hqt_chk u_hqt_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.status    (status),
	.new_index (new_index)
);
